/* hdl/mavl_pkg.sv */
`default_nettype none

package mavl_pkg;

	// Field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int WLOG_W     = 3;
	localparam int STABLE_W   = 8;
	localparam int TOTAL_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LOAD,
		ST_DIVIDE,
		ST_QUALIFY,
		ST_DELIVER
	} mavl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic fetch;
		logic div_start;
		logic qualify;
		logic deliver;
	} mavl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_idle;
		logic out_free;
	} mavl_sts_t;

endpackage

`default_nettype wire

/* hdl/mavl_ram.sv */
`default_nettype none

module mavl_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/mavl_div.sv */
`default_nettype none

module mavl_div #(
	parameter int DVD_W = 20,
	parameter int DVS_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output      logic             idle,
	output      logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   diff;
	logic             ge;

	// One restoring step: bring down the next dividend bit
	always_comb begin
		rem_sh = {rem_q, quo_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = (rem_sh >= {1'b0, dvs_q});
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Shift quotient in, hold remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign idle     = (cnt_q == '0);
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* hdl/mavl_ctrl.sv */
`default_nettype none

module mavl_ctrl import mavl_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output      logic      in_stall,
	input  wire mavl_sts_t sts,
	output      mavl_cmd_t cmd
);

	mavl_state_t state_q;
	mavl_state_t state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_FETCH;
				end
			end
			ST_FETCH:   state_n = ST_LOAD;
			ST_LOAD:    state_n = ST_DIVIDE;
			ST_DIVIDE: begin
				if (sts.div_idle) begin
					state_n = ST_QUALIFY;
				end
			end
			ST_QUALIFY: state_n = ST_DELIVER;
			ST_DELIVER: begin
				if (sts.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default:    state_n = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			ST_FETCH:   cmd.fetch     = 1'b1;
			ST_LOAD:    cmd.div_start = 1'b1;
			ST_DIVIDE:  cmd           = '0;
			ST_QUALIFY: cmd.qualify   = 1'b1;
			ST_DELIVER: cmd.deliver   = sts.out_free;
			default:    cmd           = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/mavl_dp.sv */
`default_nettype none

module mavl_dp import mavl_pkg::*; #(
	parameter int MAX_WINDOW   = 16,
	parameter int SAMPLE_LIMIT = 32767
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire mavl_cmd_t                  cmd,
	output      mavl_sts_t                  sts,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic                       level_out,
	output      logic signed [SAMPLE_W-1:0] average_out,
	output      logic                       was_clamped,
	output      logic [TOTAL_W-1:0]         sample_total,
	output      logic [TOTAL_W-1:0]         transition_total,
	output      logic [TOTAL_W-1:0]         clamp_total
);

	// Largest usable window is the biggest power of two not above MAX_WINDOW
	localparam int MAX_SHIFT = $clog2(MAX_WINDOW + 1) - 1;
	localparam int IDX_W     = (MAX_SHIFT > 0) ? MAX_SHIFT : 1;
	localparam int DEPTH     = 1 << MAX_SHIFT;
	localparam int CNT_W     = MAX_SHIFT + 1;
	localparam int SUM_W     = SAMPLE_W + MAX_SHIFT;
	localparam logic signed [SAMPLE_W-1:0] LIM_POS = SAMPLE_W'(SAMPLE_LIMIT);
	localparam logic signed [SAMPLE_W-1:0] LIM_NEG = -LIM_POS;

	// Configuration registers
	logic [WLOG_W-1:0]          wlog_q;
	logic signed [SAMPLE_W-1:0] thr_q;
	logic [STABLE_W-1:0]        stable_q;

	// Filter state
	logic signed [SAMPLE_W-1:0] samp_q;
	logic                       clamp_now_q;
	logic [IDX_W-1:0]           slot_q;
	logic [CNT_W-1:0]           fill_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic                       cur_q;
	logic                       pend_q;
	logic [STABLE_W-1:0]        run_q;
	logic [TOTAL_W-1:0]         seen_q;
	logic [TOTAL_W-1:0]         changes_q;
	logic [TOTAL_W-1:0]         clamps_q;
	logic signed [SAMPLE_W-1:0] avg_q;

	logic                       out_valid_q;
	logic                       level_out_q;
	logic signed [SAMPLE_W-1:0] average_out_q;
	logic                       was_clamped_q;
	logic [TOTAL_W-1:0]         sample_total_q;
	logic [TOTAL_W-1:0]         transition_total_q;
	logic [TOTAL_W-1:0]         clamp_total_q;

	logic [WLOG_W-1:0]          shift_w;
	logic [CNT_W-1:0]           len_w;
	logic [IDX_W-1:0]           mask_w;
	logic                       full_w;
	logic signed [SAMPLE_W-1:0] samp_c;
	logic                       clamp_c;
	logic [SAMPLE_W-1:0]        rd_data;
	logic signed [SAMPLE_W-1:0] old_w;
	logic [SUM_W-1:0]           mag_w;
	logic [SUM_W-1:0]           dividend_w;
	logic [SUM_W-1:0]           quotient;
	logic                       div_idle;
	logic [SAMPLE_W-1:0]        q16;
	logic signed [SAMPLE_W-1:0] avg_w;
	logic                       cand;
	logic [STABLE_W-1:0]        run_t;
	logic                       cur_n;
	logic                       pend_n;
	logic [STABLE_W-1:0]        run_n;
	logic                       change_n;
	logic                       restart;

	// Window geometry from the configured size
	always_comb begin
		shift_w = (int'(wlog_q) > MAX_SHIFT) ? WLOG_W'(MAX_SHIFT) : wlog_q;
		len_w   = CNT_W'(1) << shift_w;
		mask_w  = IDX_W'(len_w - CNT_W'(1));
		full_w  = (fill_q == len_w);
	end

	// Clamp the incoming sample
	always_comb begin
		samp_c  = sample_in;
		clamp_c = 1'b0;
		if (sample_in > LIM_POS) begin
			samp_c  = LIM_POS;
			clamp_c = 1'b1;
		end else if (sample_in < LIM_NEG) begin
			samp_c  = LIM_NEG;
			clamp_c = 1'b1;
		end
	end

	// Sample window; slots past the fill count read as zero
	mavl_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (cmd.fetch),
		.waddr(slot_q),
		.wdata(samp_q),
		.re   (cmd.accept),
		.raddr(slot_q),
		.rdata(rd_data)
	);

	assign old_w = full_w ? $signed(rd_data) : '0;

	// Rounded magnitude division by the fill count
	always_comb begin
		mag_w      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		dividend_w = mag_w + SUM_W'(fill_q >> 1);
	end

	mavl_div #(
		.DVD_W(SUM_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(dividend_w),
		.divisor (fill_q),
		.idle    (div_idle),
		.quotient(quotient)
	);

	// Restore the sign and qualify the candidate level
	always_comb begin
		q16      = quotient[SAMPLE_W-1:0];
		avg_w    = sum_q[SUM_W-1] ? -$signed(q16) : $signed(q16);
		cand     = (avg_w >= thr_q);
		run_t    = (cand == pend_q) ? run_q + STABLE_W'(1) : STABLE_W'(1);
		cur_n    = cur_q;
		pend_n   = cand;
		run_n    = '0;
		change_n = 1'b0;
		if (cand != cur_q) begin
			if (run_t >= stable_q) begin
				cur_n    = cand;
				change_n = 1'b1;
			end else begin
				run_n = run_t;
			end
		end
	end

	assign restart = cfg_we &&
		(cfg_index == REG_WINDOW_LOG2 || cfg_index == REG_STABLE_NEEDED);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlog_q   <= '0;
			thr_q    <= '0;
			stable_q <= STABLE_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW_LOG2:     wlog_q   <= cfg_data[WLOG_W-1:0];
				REG_LEVEL_THRESHOLD: thr_q    <= $signed(cfg_data[SAMPLE_W-1:0]);
				REG_STABLE_NEEDED:   stable_q <= cfg_data[STABLE_W-1:0];
				default:             wlog_q   <= wlog_q;
			endcase
		end
	end

	// Hold the clamped sample of the current transaction
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			samp_q      <= samp_c;
			clamp_now_q <= clamp_c;
		end
	end

	// Filter and debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			cur_q     <= 1'b0;
			pend_q    <= 1'b0;
			run_q     <= '0;
			seen_q    <= '0;
			changes_q <= '0;
			clamps_q  <= '0;
			avg_q     <= '0;
		end else if (restart) begin
			slot_q    <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			cur_q     <= 1'b0;
			pend_q    <= 1'b0;
			run_q     <= '0;
			seen_q    <= '0;
			changes_q <= '0;
			clamps_q  <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_LEVEL_THRESHOLD) begin
				run_q  <= '0;
				pend_q <= cur_q;
			end
			// Advance the window and the counters
			if (cmd.fetch) begin
				sum_q    <= sum_q - SUM_W'(old_w) + SUM_W'(samp_q);
				slot_q   <= (slot_q + IDX_W'(1)) & mask_w;
				seen_q   <= seen_q + TOTAL_W'(1);
				clamps_q <= clamps_q + TOTAL_W'(clamp_now_q);
				if (!full_w) begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
			if (cmd.qualify) begin
				avg_q     <= avg_w;
				cur_q     <= cur_n;
				pend_q    <= pend_n;
				run_q     <= run_n;
				changes_q <= changes_q + TOTAL_W'(change_n);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.deliver) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			level_out_q        <= cur_q;
			average_out_q      <= avg_q;
			was_clamped_q      <= clamp_now_q;
			sample_total_q     <= seen_q;
			transition_total_q <= changes_q;
			clamp_total_q      <= clamps_q;
		end
	end

	assign sts.div_idle = div_idle;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign level_out        = level_out_q;
	assign average_out      = average_out_q;
	assign was_clamped      = was_clamped_q;
	assign sample_total     = sample_total_q;
	assign transition_total = transition_total_q;
	assign clamp_total      = clamp_total_q;

endmodule

`default_nettype wire

/* hdl/moving_average_debounced_level_top.sv */
`default_nettype none

// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------------------
// input     in_valid / in_stall    sample_in
// output    out_valid / out_stall  level_out, average_out, was_clamped,
//                                  sample_total, transition_total, clamp_total
// config    cfg_we                 cfg_index, cfg_data
//
// After acceptance the result register loads via fetch, load, divide, qualify
// and deliver; back in idle the next sample is taken. The divider has a W-bit
// dividend, W = 16 + log2 of the largest window (20 at MAX_WINDOW 16); being
// bit-serial, one quotient bit per cycle, it sets the transaction rate.
// Reset clears state at once; the window needs no clearing pass (fill count).
// The next sample is accepted while a result still waits under out_stall.

module moving_average_debounced_level_top import mavl_pkg::*; #(
	parameter int MAX_WINDOW   = 16,
	parameter int SAMPLE_LIMIT = 32767
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic signed [SAMPLE_W-1:0] sample_in,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic                       level_out,
	output      logic signed [SAMPLE_W-1:0] average_out,
	output      logic                       was_clamped,
	output      logic [TOTAL_W-1:0]         sample_total,
	output      logic [TOTAL_W-1:0]         transition_total,
	output      logic [TOTAL_W-1:0]         clamp_total,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

	mavl_cmd_t cmd;
	mavl_sts_t sts;

	// Sequencer
	mavl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Window, divider, debounce and output register
	mavl_dp #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_LIMIT(SAMPLE_LIMIT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample_in       (sample_in),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.level_out       (level_out),
		.average_out     (average_out),
		.was_clamped     (was_clamped),
		.sample_total    (sample_total),
		.transition_total(transition_total),
		.clamp_total     (clamp_total)
	);

endmodule

`default_nettype wire
